>>> hw/rtl/lptp_pkg.sv
// Shared types and constants for the lidar polar-to-pixel block.
// No dependencies; used by every module in hw/rtl.
`default_nettype none

package lptp_pkg;

   // Field widths
   localparam int ANGLE_W = 15;
   localparam int DIST_W  = 16;
   localparam int PIX_W   = 16;
   localparam int SCALE_W = 20;
   localparam int FRAME_W = 14;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_RST = 20'd13107;
   localparam logic [FRAME_W-1:0] FRAME_RST = 14'd1000;

   // Angle reduction, in 1/64 degree: 450 deg plus two extra turns
   localparam logic [16:0] OFFSET_Q6 = 17'd74880;
   localparam logic [16:0] TURN1_Q6  = 17'd23040;
   localparam logic [16:0] TURN2_Q6  = 17'd46080;
   localparam logic [16:0] TURN3_Q6  = 17'd69120;
   localparam logic [ANGLE_W-1:0] QUAD1_Q6 = 15'd5760;
   localparam logic [ANGLE_W-1:0] QUAD2_Q6 = 15'd11520;
   localparam logic [ANGLE_W-1:0] QUAD3_Q6 = 15'd17280;
   localparam int RESID_W = 13;

   // Rotator: 30 fractional bits on x/y, angle in 2^-22 degree
   localparam int STEPS = 28;
   localparam int XY_W  = 33;
   localparam int Z_W   = 32;
   localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

   // atan(2^-i) in 2^-22 degree
   localparam logic [27:0] ATAN_TAB [STEPS] = '{
      28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
      28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
      28'd938729,    28'd469366,    28'd234683,   28'd117342,
      28'd58671,     28'd29335,     28'd14668,    28'd7334,
      28'd3667,      28'd1833,      28'd917,      28'd458,
      28'd229,       28'd115,       28'd57,       28'd29,
      28'd14,        28'd7,         28'd4,        28'd2
   };

   // One rotator stage: vector, residual angle and the sideband that rides along
   typedef struct packed {
      logic                    valid;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic [1:0]              quad;
      logic [DIST_W-1:0]       distance;
   } cordic_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] x;
      logic signed [PIX_W-1:0] y;
   } pixel_type;

endpackage

`default_nettype wire

>>> hw/rtl/lptp_cell.sv
// One rotation step of the polar-to-pixel rotator chain.
// Depends on lptp_pkg (cordic_type, ATAN_TAB).
`default_nettype none

module lptp_cell
   import lptp_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire cordic_type from_prev,
   output      cordic_type to_next
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TAB[STEP]);

   cordic_type stage_ff, stage_in;
   logic signed [XY_W-1:0] dx, dy;

   // shifted cross terms (floor shift)
   assign dx = $signed(from_prev.y) >>> STEP;
   assign dy = $signed(from_prev.x) >>> STEP;

   // rotate toward zero residual angle
   always_comb begin
      stage_in = from_prev;
      if (!from_prev.z[Z_W-1]) begin
         stage_in.x = from_prev.x - dx;
         stage_in.y = from_prev.y + dy;
         stage_in.z = from_prev.z - ATAN;
      end else begin
         stage_in.x = from_prev.x + dx;
         stage_in.y = from_prev.y - dy;
         stage_in.z = from_prev.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   stage_ff <= '0;
      else if (en) stage_ff <= stage_in;
   end

   assign to_next = stage_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lptp_out.sv
// Output register plus skid entry for the pixel result channel.
// Depends on lptp_pkg (pixel_type).
`default_nettype none

module lptp_out
   import lptp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire pixel_type push_data,
   output      logic      push_ready,
   output      logic      rsp_valid,
   input  wire logic      rsp_ready,
   output      pixel_type rsp_data
);

   pixel_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic pop;

   assign pop        = out_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;

   // skid entry drains first; a new item lands in the skid only on a stall
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lidar_polar_to_pixel.sv
// Top level: lidar sample (angle, distance) to display pixel position.
// Depends on lptp_pkg, lptp_cell, lptp_out.
//
// Accepts one item per clock while req_ready is high and returns one pixel
// item per item, in order. From acceptance to rsp_valid an item passes two
// angle-reduction stages, a chain of 28 rotator cells (one rotation step
// each), four stages for rounding, quadrant fold and the two multiplies,
// then the output register. req_ready is registered and drops only while
// both the output register and its skid entry hold items the consumer has
// not taken. Configuration registers are sampled by the trailing stages,
// so write them only while no item is in flight.
`default_nettype none

module lidar_polar_to_pixel
   import lptp_pkg::*;
#(
   parameter int TRIG_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [ANGLE_W-1:0]    req_angle_q6,
   input  wire logic [DIST_W-1:0]     req_distance_q2,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic signed [PIX_W-1:0] rsp_pixel_x,
   output      logic signed [PIX_W-1:0] rsp_pixel_y,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SCALE_W-1:0]    csr_data
);

   // sine/cosine width, product widths
   localparam int CS_W  = TRIG_BITS + 2;
   localparam int P_W   = CS_W + DIST_W + 1;
   localparam int MM_W  = 17;
   localparam int SP_W  = MM_W + SCALE_W + 1;
   localparam int SUM_W = SP_W + 1;
   localparam int Q_W   = SUM_W - 16;
   localparam logic signed [XY_W:0]  HALF  = (XY_W+1)'(1) << (29 - TRIG_BITS);
   localparam logic signed [P_W-1:0] DBIAS = (P_W'(1) << (TRIG_BITS + 2)) - P_W'(1);
   localparam logic signed [SUM_W-1:0] BIAS16 = SUM_W'(17'h0FFFF);
   localparam logic signed [Q_W-1:0] PMAX = Q_W'(2**(PIX_W-1) - 1);
   localparam logic signed [Q_W-1:0] PMIN = -Q_W'(2**(PIX_W-1));

   // truncating divide by 2^16 and clamp to the pixel range
   function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] biased;
      logic signed [Q_W-1:0]   quo;
      biased = v + (v[SUM_W-1] ? BIAS16 : '0);
      quo    = biased[SUM_W-1:16];
      if (quo > PMAX) return PMAX[PIX_W-1:0];
      if (quo < PMIN) return PMIN[PIX_W-1:0];
      return quo[PIX_W-1:0];
   endfunction

   logic en;

   // ---------------- configuration registers ----------------
   logic [SCALE_W-1:0] scale_ff;
   logic [FRAME_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RST;
         width_ff  <= FRAME_RST;
         height_ff <= FRAME_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[FRAME_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = en;

   // ---------------- angle remap: (450 deg - angle) mod 360 ----------------
   logic [16:0]        ang_off;
   logic [16:0]        ang_wrap;
   logic [ANGLE_W-1:0] a_ff, a_in;
   logic [DIST_W-1:0]  dist1_ff;
   logic               v1_ff;

   always_comb begin
      ang_off = OFFSET_Q6 - {2'b00, req_angle_q6};
      if (ang_off >= TURN3_Q6)      ang_wrap = ang_off - TURN3_Q6;
      else if (ang_off >= TURN2_Q6) ang_wrap = ang_off - TURN2_Q6;
      else if (ang_off >= TURN1_Q6) ang_wrap = ang_off - TURN1_Q6;
      else                          ang_wrap = ang_off;
      a_in = ang_wrap[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         dist1_ff <= req_distance_q2;
      end
      if (reset)   v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end

   // ---------------- quadrant split, rotator seed ----------------
   cordic_type       head_ff, head_in;
   logic [ANGLE_W-1:0] resid;

   always_comb begin
      head_in          = '0;
      head_in.valid    = v1_ff;
      head_in.distance = dist1_ff;
      if (a_ff >= QUAD3_Q6) begin
         head_in.quad = 2'd3;
         resid        = a_ff - QUAD3_Q6;
      end else if (a_ff >= QUAD2_Q6) begin
         head_in.quad = 2'd2;
         resid        = a_ff - QUAD2_Q6;
      end else if (a_ff >= QUAD1_Q6) begin
         head_in.quad = 2'd1;
         resid        = a_ff - QUAD1_Q6;
      end else begin
         head_in.quad = 2'd0;
         resid        = a_ff;
      end
      head_in.x = GAIN_Q30;
      head_in.y = '0;
      // 1/64 degree to 2^-22 degree
      head_in.z = Z_W'({resid[RESID_W-1:0], 16'h0000});
   end

   always_ff @(posedge clock) begin
      if (reset)   head_ff <= '0;
      else if (en) head_ff <= head_in;
   end

   // ---------------- rotator chain ----------------
   cordic_type chain [STEPS+1];
   assign chain[0] = head_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      lptp_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .from_prev (chain[i]),
         .to_next   (chain[i+1])
      );
   end

   // ---------------- round to TRIG_BITS, quadrant fold ----------------
   cordic_type               tail;
   logic signed [XY_W:0]     x_rnd, y_rnd;
   logic signed [CS_W-1:0]   c_val, s_val, cs_in, sn_in, cs_ff, sn_ff;
   logic [DIST_W-1:0]        dist2_ff;
   logic                     v2_ff;

   assign tail  = chain[STEPS];
   assign x_rnd = (XY_W+1)'(tail.x) + HALF;
   assign y_rnd = (XY_W+1)'(tail.y) + HALF;
   assign c_val = x_rnd[30-TRIG_BITS +: CS_W];
   assign s_val = y_rnd[30-TRIG_BITS +: CS_W];

   always_comb begin
      case (tail.quad)
         2'd0:    begin cs_in = c_val;  sn_in = s_val;  end
         2'd1:    begin cs_in = -s_val; sn_in = c_val;  end
         2'd2:    begin cs_in = -c_val; sn_in = -s_val; end
         default: begin cs_in = s_val;  sn_in = -c_val; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff    <= cs_in;
         sn_ff    <= sn_in;
         dist2_ff <= tail.distance;
      end
      if (reset)   v2_ff <= 1'b0;
      else if (en) v2_ff <= tail.valid;
   end

   // ---------------- distance times cosine / sine ----------------
   logic signed [P_W-1:0] px_prod_ff, py_prod_ff;
   logic                  v3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_prod_ff <= P_W'($signed({1'b0, dist2_ff})) * P_W'(cs_ff);
         py_prod_ff <= P_W'($signed({1'b0, dist2_ff})) * P_W'(sn_ff);
      end
      if (reset)   v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   // ---------------- to whole millimetres, truncating ----------------
   logic signed [P_W-1:0]  px_bias, py_bias;
   logic signed [MM_W-1:0] xmm_ff, ymm_ff;
   logic                   v4_ff;

   assign px_bias = px_prod_ff + (px_prod_ff[P_W-1] ? DBIAS : '0);
   assign py_bias = py_prod_ff + (py_prod_ff[P_W-1] ? DBIAS : '0);

   always_ff @(posedge clock) begin
      if (en) begin
         xmm_ff <= px_bias[TRIG_BITS+2 +: MM_W];
         ymm_ff <= py_bias[TRIG_BITS+2 +: MM_W];
      end
      if (reset)   v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   // ---------------- scale to pixels ----------------
   logic signed [SP_W-1:0] xs_ff, ys_ff;
   logic                   v5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff <= SP_W'(xmm_ff) * SP_W'($signed({1'b0, scale_ff}));
         ys_ff <= SP_W'(ymm_ff) * SP_W'($signed({1'b0, scale_ff}));
      end
      if (reset)   v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   // ---------------- frame centre offset, truncate, clamp ----------------
   logic signed [SUM_W-1:0] cx, cy, sum_x, sum_y;
   pixel_type               pix, rsp_pix;

   assign cx    = SUM_W'($signed({1'b0, width_ff[FRAME_W-1:1], 16'h0000}));
   assign cy    = SUM_W'($signed({1'b0, height_ff[FRAME_W-1:1], 16'h0000}));
   assign sum_x = SUM_W'(xs_ff) + cx;
   assign sum_y = cy - SUM_W'(ys_ff);
   assign pix.x = sat_pix(sum_x);
   assign pix.y = sat_pix(sum_y);

   lptp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (v5_ff),
      .push_data  (pix),
      .push_ready (en),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_pix)
   );

   assign rsp_pixel_x = rsp_pix.x;
   assign rsp_pixel_y = rsp_pix.y;

endmodule

`default_nettype wire

>>> hw/rtl/lptp_check.sv
// Port-level checks for lidar_polar_to_pixel, attached with a bind.
// Depends on lptp_pkg for port widths.
`default_nettype none

module lptp_check
   import lptp_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [PIX_W-1:0] rsp_pixel_x,
   input wire logic signed [PIX_W-1:0] rsp_pixel_y
);

   // items accepted but not yet delivered
   logic [6:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
         inflight_in = inflight_ff + 7'd1;
      else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
         inflight_in = inflight_ff - 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= '0;
      else       inflight_ff <= inflight_in;
   end

   // no result shows up right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a result is never invented
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 7'd0)
      else $error("result without an outstanding item");

   // input stalls only while a result is waiting at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result pending");

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
                                  && $stable(rsp_pixel_y))
      else $error("result dropped or changed while stalled");

endmodule

bind lidar_polar_to_pixel lptp_check u_lptp_check (.*);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for lidar_polar_to_pixel: streams lidar samples with random
// handshake gaps and checks every pixel item against an in-bench CORDIC predictor.
// Depends on lptp_pkg and the lidar_polar_to_pixel RTL.

module testbench;
   import lptp_pkg::*;

   localparam int TRIG_BITS    = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 40;

   // Register index that decodes to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [SCALE_W-1:0] DEFAULT_SCALE = 20'd13107;
   localparam logic [FRAME_W-1:0] DEFAULT_FRAME = 14'd1000;

   // Angle remap: 450 deg plus two spare turns, in 1/64 degree
   localparam longint SAMPLE_OFFSET = 74880;
   localparam longint FULL_TURN     = 23040;
   localparam longint QUARTER_TURN  = 5760;

   // Rotation-mode CORDIC, 30 fractional bits, angle in 2^-22 degree
   localparam int     ROT_STEPS  = 28;
   localparam longint ROT_GAIN   = 652032874;
   localparam longint ROUND_HALF = longint'(1) <<< (29 - TRIG_BITS);
   localparam longint ARCTAN_STEP [ROT_STEPS] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [ANGLE_W-1:0]       req_angle_q6;
   logic [DIST_W-1:0]        req_distance_q2;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [PIX_W-1:0]  rsp_pixel_x;
   logic signed [PIX_W-1:0]  rsp_pixel_y;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [SCALE_W-1:0]       csr_data;

   // Shadow copy of the display registers
   logic [SCALE_W-1:0]       scale_setting;
   logic [FRAME_W-1:0]       width_setting;
   logic [FRAME_W-1:0]       height_setting;

   pixel_type pending_pixels [$];
   int        fail_count;
   int        cycle_count;
   bit        sender_steady;
   bit        receiver_steady;
   int        hold_request;
   int        stall_left;

   lidar_polar_to_pixel #(.TRIG_BITS(TRIG_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_angle_q6    (req_angle_q6),
      .req_distance_q2 (req_distance_q2),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Division by 2^s rounding toward zero
   function automatic longint toward_zero(input longint v, input int s);
      if (v >= 0)
         return v >>> s;
      return -((-v) >>> s);
   endfunction

   function automatic logic signed [PIX_W-1:0] clamp16(input longint v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return v[PIX_W-1:0];
   endfunction

   // Expected pixel for one sample under the current register settings
   function automatic pixel_type predict_pixel(input logic [ANGLE_W-1:0] angle,
                                               input logic [DIST_W-1:0] distance);
      longint    turned, resid, x, y, z, dx, dy, c, s, cs, sn, xmm, ymm, px, py;
      int        quad;
      pixel_type result;
      turned = (SAMPLE_OFFSET - longint'(angle)) % FULL_TURN;
      quad   = int'(turned / QUARTER_TURN);
      resid  = turned % QUARTER_TURN;
      x = ROT_GAIN;
      y = 0;
      z = resid <<< 16;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_STEP[i];
         end
      end
      c = (x + ROUND_HALF) >>> (30 - TRIG_BITS);
      s = (y + ROUND_HALF) >>> (30 - TRIG_BITS);
      // fold the quadrant back in
      case (quad)
         0: begin
            cs = c;  sn = s;
         end
         1: begin
            cs = -s; sn = c;
         end
         2: begin
            cs = -c; sn = -s;
         end
         default: begin
            cs = s;  sn = -c;
         end
      endcase
      xmm = toward_zero(longint'(distance) * cs, TRIG_BITS + 2);
      ymm = toward_zero(longint'(distance) * sn, TRIG_BITS + 2);
      px = toward_zero(xmm * longint'(scale_setting)
                       + (longint'(width_setting >> 1) <<< 16), 16);
      py = toward_zero((longint'(height_setting >> 1) <<< 16)
                       - ymm * longint'(scale_setting), 16);
      result.x = clamp16(px);
      result.y = clamp16(py);
      return result;
   endfunction

   // Offer one sample, wait for acceptance, queue its expected pixel
   task automatic send_sample(input logic [ANGLE_W-1:0] angle,
                              input logic [DIST_W-1:0] distance);
      int gap;
      gap = 0;
      if (!sender_steady && $urandom_range(0, 99) < 7)
         gap = 1;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_angle_q6    <= angle;
      req_distance_q2 <= distance;
      do
         @(posedge clock);
      while (!req_ready);
      pending_pixels.push_back(predict_pixel(angle, distance));
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Quiet the input and wait until every pixel is back and the pipe is empty
   task automatic settle();
      stop_sending();
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SCALE:  scale_setting  = data;
         CSR_WIDTH:  width_setting  = data[FRAME_W-1:0];
         CSR_HEIGHT: height_setting = data[FRAME_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      if ($urandom_range(0, 9) < 8)
         return ANGLE_W'($urandom_range(0, 23039));
      return ANGLE_W'($urandom_range(0, 32767));
   endfunction

   function automatic logic [DIST_W-1:0] random_distance();
      if ($urandom_range(0, 9) < 2)
         return DIST_W'($urandom_range(0, 255));
      return DIST_W'($urandom_range(0, 65535));
   endfunction

   // Reset values: quadrant edges, full turn and above, distance extremes
   task automatic test_reset_values();
      send_sample(15'd0, 16'd65535);
      send_sample(15'd1, 16'd65535);
      send_sample(15'd5759, 16'd65535);
      send_sample(15'd5760, 16'd65535);
      send_sample(15'd11520, 16'd65535);
      send_sample(15'd17280, 16'd65535);
      send_sample(15'd23039, 16'd65535);
      send_sample(15'd23040, 16'd65535);
      send_sample(15'd32767, 16'd65535);
      send_sample(15'd7000, 16'd0);
      send_sample(15'd2880, 16'd1);
      settle();
   endtask

   // Saturation, zero scale, odd and tiny frames, write to an unused index
   task automatic test_config_extremes();
      write_reg(CSR_SCALE, 20'hFFFFF);
      write_reg(CSR_WIDTH, 20'd16383);
      write_reg(CSR_HEIGHT, 20'd1);
      send_sample(15'd0, 16'd65535);
      send_sample(15'd5760, 16'd65535);
      send_sample(15'd11520, 16'd65535);
      send_sample(15'd17280, 16'd65535);
      settle();
      // zero scale puts everything on the centre
      write_reg(CSR_SCALE, 20'd0);
      send_sample(15'd1234, 16'd65535);
      send_sample(15'd20000, 16'd40000);
      settle();
      write_reg(CSR_SCALE, 20'd1);
      write_reg(CSR_WIDTH, 20'd0);
      write_reg(CSR_HEIGHT, 20'd0);
      send_sample(15'd3000, 16'd65535);
      send_sample(15'd14000, 16'd65535);
      settle();
      // unused index must leave the registers alone
      write_reg(CSR_UNUSED, 20'h5A5A5);
      send_sample(15'd9000, 16'd50000);
      send_sample(15'd21000, 16'd12345);
      settle();
   endtask

   // Random samples over several register settings, both sides idling
   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_reg(CSR_SCALE, SCALE_W'($urandom_range(1, 32768)));
            1: write_reg(CSR_SCALE, SCALE_W'($urandom_range(32768, 262143)));
            2: write_reg(CSR_SCALE, SCALE_W'($urandom_range(0, 1048575)));
            default: write_reg(CSR_SCALE, DEFAULT_SCALE);
         endcase
         // full 20-bit data: upper bits must be dropped by the frame registers
         write_reg(CSR_WIDTH, SCALE_W'($urandom_range(0, 1048575)));
         write_reg(CSR_HEIGHT, SCALE_W'($urandom_range(0, 1048575)));
         repeat (50) send_sample(random_angle(), random_distance());
         settle();
      end
   endtask

   // Receiver holds off long enough for the pipe to fill and stall the input
   task automatic test_full_backpressure();
      write_reg(CSR_SCALE, 20'd20000);
      write_reg(CSR_WIDTH, 20'd8192);
      write_reg(CSR_HEIGHT, 20'd2);
      sender_steady = 1'b1;
      hold_request  = 200;
      repeat (80) send_sample(random_angle(), random_distance());
      sender_steady = 1'b0;
      settle();
   endtask

   // Long stretch with no idling on either side
   task automatic test_unbroken_stream();
      write_reg(CSR_SCALE, 20'd13107);
      write_reg(CSR_WIDTH, 20'd1001);
      write_reg(CSR_HEIGHT, 20'd777);
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      repeat (100) send_sample(random_angle(), random_distance());
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      settle();
   endtask

   // Receiver: random stalls plus requested long hold-offs
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= receiver_steady || ($urandom_range(0, 99) >= 7);
      end
   end

   // Compare each accepted pixel item with the oldest expectation
   always @(posedge clock) begin : check_pixel
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected pixel item x=%0d y=%0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.x) begin
               fail_count++;
               $display("%0t: pixel_x expected %0d got %0d", $time, want.x, rsp_pixel_x);
            end
            if (rsp_pixel_y !== want.y) begin
               fail_count++;
               $display("%0t: pixel_y expected %0d got %0d", $time, want.y, rsp_pixel_y);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL lidar_polar_to_pixel");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_angle_q6    = '0;
      req_distance_q2 = '0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_SCALE;
      csr_data        = '0;
      scale_setting   = DEFAULT_SCALE;
      width_setting   = DEFAULT_FRAME;
      height_setting  = DEFAULT_FRAME;
      fail_count      = 0;
      cycle_count     = 0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_request    = 0;
      stall_left      = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_config_extremes();
      test_random_phases();
      test_full_backpressure();
      test_unbroken_stream();
      settle();

      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("PASS lidar_polar_to_pixel");
      else
         $display("FAIL lidar_polar_to_pixel");
      $finish;
   end

endmodule

>>> lidar_polar_to_pixel.f
hw/rtl/lptp_pkg.sv
hw/rtl/lptp_cell.sv
hw/rtl/lptp_out.sv
hw/rtl/lidar_polar_to_pixel.sv
hw/rtl/lptp_check.sv
sim/testbench.sv
